### rtl/abr_pkg.sv
// ----------------------------------------------------------------------------
// abr_pkg
// Shared types and constants for the throughput-driven bitrate selector.
// ----------------------------------------------------------------------------
package abr_pkg;

    // Field widths fixed by the interface.
    localparam int BYTES_W     = 24;
    localparam int DUR_W       = 32;
    localparam int KBPS_W      = 24;
    localparam int AVG_W       = 32;
    localparam int RATE_W      = 16;
    localparam int LEVEL_W     = 3;
    localparam int ALPHA_W     = 17;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    // Number of rate registers and the default parameter values.
    localparam int RATE_SLOTS        = 6;
    localparam int DEF_MAX_LEVELS    = 6;
    localparam int DEF_AVG_FRAC_BITS = 8;

    // bytes * 8000 needs 13 extra bits.
    localparam int DIVIDEND_W = BYTES_W + 13;

    // Fixed-point constants.
    localparam logic [ALPHA_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [KBPS_W-1:0]  KBPS_MAX = 24'hFFFFFF;
    localparam int                 PROD_W   = ALPHA_W + AVG_W;
    localparam logic [PROD_W-1:0]  HALF_Q16 = PROD_W'(32768);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_COUNT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_0      = 3'd2;

    // Reset values of the configuration registers.
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd32768;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 3'd1;

    // One input request.
    typedef struct packed {
        logic [BYTES_W-1:0] chunk_bytes;
        logic [DUR_W-1:0]   duration_us;
    } abr_in_t;

    // One result.
    typedef struct packed {
        logic [KBPS_W-1:0]  measured_kbps;
        logic [AVG_W-1:0]   average_kbps_q8;
        logic [RATE_W-1:0]  chosen_rate;
        logic [LEVEL_W-1:0] chosen_level;
        logic               zero_time;
        logic               clipped;
    } abr_out_t;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [ALPHA_W-1:0]                 alpha_q16;
        logic [LEVEL_W-1:0]                 level_count;
        logic [RATE_SLOTS-1:0][RATE_W-1:0]  rate_level;
    } abr_cfg_t;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DUR_W-1:0]      divisor;
    } abr_div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } abr_div_rsp_t;

endpackage

### rtl/abr_throughput_bitrate_select.sv
// ----------------------------------------------------------------------------
// abr_throughput_bitrate_select
// Chunk throughput measurement, EWMA averaging and bitrate level selection.
// ----------------------------------------------------------------------------
// The bit-serial divider for bytes*8000/duration hands over the quotient
// through a registered done flag; a zero duration skips it. The shared 17x32
// multiplier runs twice for the average update, then the S_SUM state sums the
// products. The level scan tests one level per cycle from the top valid level
// downward until one qualifies or level zero is reached, and S_DONE then loads
// the output register. The block takes one request at a time, and the next
// request can be accepted in the same cycle that the result is offered. A
// finished result sits in the output register while the next request is
// accepted, and a result that is still stalled there holds the following one
// back. Configuration writes are always ready and must only be issued while
// the block is idle.
module abr_throughput_bitrate_select
    import abr_pkg::*;
#(
    parameter int MAX_LEVELS    = DEF_MAX_LEVELS,
    parameter int AVG_FRAC_BITS = DEF_AVG_FRAC_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  abr_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output abr_out_t               out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DIV     = 7'b0000010,
        S_MUL_M   = 7'b0000100,
        S_MUL_AVG = 7'b0001000,
        S_SUM     = 7'b0010000,
        S_SCAN    = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(MAX_LEVELS - 1);
    localparam int                 LHS_W     = RATE_W + 2 + AVG_FRAC_BITS;
    localparam int                 CMP_W     = AVG_W + 2;

    state_t               state_reg;
    state_t               state_next;
    logic [KBPS_W-1:0]    meas_reg;
    logic [KBPS_W-1:0]    meas_next;
    logic                 zero_reg;
    logic                 zero_next;
    logic                 clip_reg;
    logic                 clip_next;
    logic [AVG_W-1:0]     avg_reg;
    logic [AVG_W-1:0]     avg_next;
    logic [PROD_W-1:0]    acc_reg;
    logic [PROD_W-1:0]    acc_next;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    prod_next;
    logic [LEVEL_W-1:0]   idx_reg;
    logic [LEVEL_W-1:0]   idx_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    abr_out_t             out_reg;
    abr_out_t             out_next;

    abr_cfg_t             cfg;
    abr_div_req_t         div_req;
    abr_div_rsp_t         div_rsp;

    logic                 in_accept;
    logic [ALPHA_W-1:0]   alpha_eff;
    logic [ALPHA_W-1:0]   mul_a;
    logic [AVG_W-1:0]     mul_b;
    logic [PROD_W-1:0]    mul_p;
    logic [AVG_W-1:0]     meas_scaled;
    logic [PROD_W:0]      sum_full;
    logic [LEVEL_W-1:0]   top_idx;
    logic [LHS_W-1:0]     lhs;
    logic                 qualifies;

    // Configuration register file; writes are taken every cycle.
    assign cfg_ready = 1'b1;

    abr_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The divider starts on acceptance of a request with a nonzero duration.
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid & ~in_stall;

    assign div_req.start    = in_accept & (in_data.duration_us != '0);
    assign div_req.dividend = (DIVIDEND_W'(in_data.chunk_bytes) << 13)
                            - (DIVIDEND_W'(in_data.chunk_bytes) << 7)
                            - (DIVIDEND_W'(in_data.chunk_bytes) << 6);
    assign div_req.divisor  = in_data.duration_us;

    abr_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Alpha above one acts as one.
    assign alpha_eff   = (cfg.alpha_q16 > ONE_Q16) ? ONE_Q16 : cfg.alpha_q16;
    assign meas_scaled = AVG_W'(meas_reg) << AVG_FRAC_BITS;

    // Shared multiplier: alpha times the new sample, then (1 - alpha) times the average.
    always_comb
    begin
        if (state_reg == S_MUL_M)
        begin
            mul_a = alpha_eff;
            mul_b = meas_scaled;
        end
        else
        begin
            mul_a = ONE_Q16 - alpha_eff;
            mul_b = avg_reg;
        end
    end

    assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign sum_full = {1'b0, acc_reg} + {1'b0, prod_reg};

    // Top valid level after clamping the level count into range.
    always_comb
    begin
        if (cfg.level_count == '0)
        begin
            top_idx = '0;
        end
        else if (cfg.level_count > LEVEL_W'(MAX_LEVELS))
        begin
            top_idx = TOP_LEVEL;
        end
        else
        begin
            top_idx = cfg.level_count - 1'b1;
        end
    end

    // Level test: 3 * rate * 2^frac < 2 * average.
    assign lhs       = LHS_W'(LHS_W'(cfg.rate_level[idx_reg]) * LHS_W'(3)) << AVG_FRAC_BITS;
    assign qualifies = (CMP_W'(lhs) < (CMP_W'(avg_reg) << 1));

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        meas_next      = meas_reg;
        zero_next      = zero_reg;
        clip_next      = clip_reg;
        avg_next       = avg_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_data.duration_us == '0)
                    begin
                        meas_next  = KBPS_MAX;
                        zero_next  = 1'b1;
                        clip_next  = 1'b0;
                        state_next = S_MUL_M;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    zero_next = 1'b0;
                    if (div_rsp.quotient[DIVIDEND_W-1:KBPS_W] != '0)
                    begin
                        meas_next = KBPS_MAX;
                        clip_next = 1'b1;
                    end
                    else
                    begin
                        meas_next = div_rsp.quotient[KBPS_W-1:0];
                        clip_next = 1'b0;
                    end
                    state_next = S_MUL_M;
                end
            end
            S_MUL_M:
            begin
                prod_next  = mul_p;
                state_next = S_MUL_AVG;
            end
            S_MUL_AVG:
            begin
                acc_next   = prod_reg + HALF_Q16;
                prod_next  = mul_p;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                avg_next   = sum_full[AVG_W+15:16];
                idx_next   = top_idx;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (qualifies || idx_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                // Wait until the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_next.measured_kbps   = meas_reg;
                    out_next.average_kbps_q8 = avg_reg;
                    out_next.chosen_rate     = cfg.rate_level[idx_reg];
                    out_next.chosen_level    = idx_reg;
                    out_next.zero_time       = zero_reg;
                    out_next.clipped         = clip_reg;
                    out_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and the running average.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            avg_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            avg_reg       <= avg_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        meas_reg <= meas_next;
        zero_reg <= zero_next;
        clip_reg <= clip_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        idx_reg  <= idx_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### rtl/abr_cfg_regs.sv
// ----------------------------------------------------------------------------
// abr_cfg_regs
// Configuration register file: alpha, level count and the six rate levels.
// ----------------------------------------------------------------------------
module abr_cfg_regs
    import abr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output abr_cfg_t               cfg
);

    abr_cfg_t cfg_reg;
    abr_cfg_t cfg_next;

    // Decode the register index of a write request.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_ALPHA:
                begin
                    cfg_next.alpha_q16 = wr_data[ALPHA_W-1:0];
                end
                CFG_LEVEL_COUNT:
                begin
                    cfg_next.level_count = wr_data[LEVEL_W-1:0];
                end
                default:
                begin
                    if (wr_index >= CFG_RATE_0)
                    begin
                        cfg_next.rate_level[wr_index - CFG_RATE_0] = wr_data[RATE_W-1:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_q16   <= ALPHA_RESET;
            cfg_reg.level_count <= LEVEL_RESET;
            cfg_reg.rate_level  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/abr_divider.sv
// ----------------------------------------------------------------------------
// abr_divider
// Restoring radix-2 divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module abr_divider
    import abr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  abr_div_req_t req,
    output abr_div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [DUR_W-1:0]      rem_reg;
    logic [DUR_W-1:0]      rem_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [DUR_W-1:0]      divisor_reg;
    logic [DUR_W-1:0]      divisor_next;
    logic [DUR_W:0]        trial;
    logic                  fits;

    // One trial subtraction per cycle; the dividend shifts out as quotient bits shift in.
    always_comb
    begin
        trial        = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits         = (trial >= {1'b0, divisor_reg});
        count_next   = count_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            count_next   = CNT_W'(DIVIDEND_W);
            busy_next    = 1'b1;
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? DUR_W'(trial - {1'b0, divisor_reg}) : trial[DUR_W-1:0];
            quo_next   = {quo_reg[DIVIDEND_W-2:0], fits};
            count_next = count_reg - 1'b1;
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### verif/abr_throughput_bitrate_select_test.sv
// ----------------------------------------------------------------------------
// abr_throughput_bitrate_select_test
// Self-checking bench for the chunk throughput and bitrate selection block.
// A short scripted sequence covers the field extremes, saturation, the level
// scan and odd register settings. Random chunk reports follow under several
// register settings and three idle patterns. Results are checked against the
// script's value or a behavioral copy of throughput, average and level math.
// ----------------------------------------------------------------------------
module abr_throughput_bitrate_select_test;
    import abr_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int QUIET_CYCLES   = 8;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_ITEMS   = 990;
    localparam int SEGMENTS       = 9;
    localparam int HOLD_AT        = 150;
    localparam int HOLD_CYCLES    = 400;
    localparam int TIMEOUT_CYCLES = 500000;

    // One line of the scripted sequence: a register write or a chunk report.
    typedef struct {
        bit                     is_write;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        abr_in_t                chunk;
        bit                     typed;
        abr_out_t               known;
    } script_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    abr_in_t                in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    abr_out_t               out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Register copies and the running average as the block should hold them.
    logic [ALPHA_W-1:0]     set_alpha = ALPHA_RESET;
    logic [LEVEL_W-1:0]     set_levels = LEVEL_RESET;
    logic [RATE_W-1:0]      set_rate [RATE_SLOTS];
    logic [AVG_W-1:0]       ewma_q8 = '0;

    abr_out_t               due_selections [$];
    script_row_t            plan [$];
    int                     mismatches = 0;
    int                     results_seen = 0;
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;

    abr_throughput_bitrate_select u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Throughput, average update and level pick for one accepted request.
    function automatic abr_out_t predict_chunk(input abr_in_t chunk);
        abr_out_t    res;
        logic [63:0] quot;
        logic [63:0] weight;
        logic [63:0] acc;
        logic [63:0] lhs;
        logic [63:0] rhs;
        int          levels;
        int          lvl;
        res = '0;
        if (chunk.duration_us == '0)
        begin
            res.measured_kbps = KBPS_MAX;
            res.zero_time     = 1'b1;
        end
        else
        begin
            quot = (64'(chunk.chunk_bytes) * 64'd8000) / 64'(chunk.duration_us);
            if (quot > 64'(KBPS_MAX))
            begin
                res.measured_kbps = KBPS_MAX;
                res.clipped       = 1'b1;
            end
            else
            begin
                res.measured_kbps = quot[KBPS_W-1:0];
            end
        end

        // Alpha saturates at one; the sum rounds half up before the shift.
        weight  = (set_alpha > ONE_Q16) ? 64'(ONE_Q16) : 64'(set_alpha);
        acc     = weight * (64'(res.measured_kbps) << DEF_AVG_FRAC_BITS)
                + (64'(ONE_Q16) - weight) * 64'(ewma_q8) + 64'd32768;
        ewma_q8 = acc[AVG_W+15:16];
        res.average_kbps_q8 = ewma_q8;

        // The highest qualifying index wins, whatever the order of the rates.
        levels = (set_levels == '0) ? 1 : int'(set_levels);
        if (levels > DEF_MAX_LEVELS)
            levels = DEF_MAX_LEVELS;
        lvl = 0;
        rhs = 64'd2 * 64'(ewma_q8);
        for (int i = 0; i < levels; i++)
        begin
            lhs = (64'd3 * 64'(set_rate[i])) << DEF_AVG_FRAC_BITS;
            if (lhs < rhs)
                lvl = i;
        end
        res.chosen_rate  = set_rate[lvl];
        res.chosen_level = LEVEL_W'(lvl);
        return res;
    endfunction

    function automatic abr_in_t random_chunk();
        abr_in_t c;
        c.chunk_bytes = BYTES_W'($urandom() >> $urandom_range(31, 8));
        case ($urandom_range(19))
            0:       c.duration_us = '0;
            1:       c.duration_us = $urandom();
            default: c.duration_us = $urandom() >> $urandom_range(31, 0);
        endcase
        return c;
    endfunction

    function automatic void add_write(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] value);
        script_row_t r;
        r.is_write  = 1'b1;
        r.reg_index = idx;
        r.reg_value = value;
        r.chunk     = '0;
        r.typed     = 1'b0;
        r.known     = '0;
        plan.insert(plan.size(), r);
    endfunction

    function automatic void add_chunk(input logic [BYTES_W-1:0] bytes,
                                      input logic [DUR_W-1:0] dur,
                                      input bit typed, input abr_out_t known);
        script_row_t r;
        r.is_write          = 1'b0;
        r.reg_index         = '0;
        r.reg_value         = '0;
        r.chunk.chunk_bytes = bytes;
        r.chunk.duration_us = dur;
        r.typed             = typed;
        r.known             = known;
        plan.insert(plan.size(), r);
    endfunction

    task automatic compare_field(input string label, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, label, want, got);
            mismatches++;
        end
    endtask

    task automatic check_selection(input abr_out_t got);
        abr_out_t want;
        if (due_selections.size() == 0)
        begin
            $display("%0t: result with no request outstanding, expected none, actual %h",
                     $time, got);
            mismatches++;
        end
        else
        begin
            want = due_selections.pop_front();
            compare_field("measured_kbps", 32'(want.measured_kbps), 32'(got.measured_kbps));
            compare_field("average_kbps_q8", want.average_kbps_q8, got.average_kbps_q8);
            compare_field("chosen_rate", 32'(want.chosen_rate), 32'(got.chosen_rate));
            compare_field("chosen_level", 32'(want.chosen_level), 32'(got.chosen_level));
            compare_field("zero_time", 32'(want.zero_time), 32'(got.zero_time));
            compare_field("clipped", 32'(want.clipped), 32'(got.clipped));
        end
    endtask

    // Offers one request; the expectation is queued when it is accepted.
    task automatic send_chunk(input abr_in_t chunk, input bit typed,
                              input abr_out_t known);
        abr_out_t guess;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            in_data  <= random_chunk();
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= chunk;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        guess = predict_chunk(chunk);
        due_selections.insert(due_selections.size(), typed ? known : guess);
        @(negedge clk);
    endtask

    // Writes one register; the caller lowers cfg_valid after the last write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_ALPHA)
            set_alpha = value[ALPHA_W-1:0];
        else if (idx == CFG_LEVEL_COUNT)
            set_levels = value[LEVEL_W-1:0];
        else
            set_rate[idx - CFG_RATE_0] = value[RATE_W-1:0];
        @(negedge clk);
    endtask

    // Stops offering requests and waits until every result has come back.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (due_selections.size() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic load_random_settings();
        logic [CFG_DATA_W-1:0] alpha;
        int unsigned           rate;
        bit                    jumbled;
        case ($urandom_range(4))
            0:       alpha = '0;
            1:       alpha = ONE_Q16;
            2:       alpha = CFG_DATA_W'($urandom_range(131071, 65537));
            default: alpha = CFG_DATA_W'($urandom_range(65536));
        endcase
        write_reg(CFG_ALPHA, alpha);
        write_reg(CFG_LEVEL_COUNT, CFG_DATA_W'($urandom_range(7)));

        // Mostly ascending rates, now and then an unordered set.
        jumbled = ($urandom_range(4) == 0);
        rate    = 0;
        for (int i = 0; i < RATE_SLOTS; i++)
        begin
            if (jumbled)
                rate = $urandom_range(65535);
            else
                rate = rate + ($urandom() >> $urandom_range(31, 17));
            if (rate > 65535)
                rate = 65535;
            write_reg(CFG_RATE_0 + CFG_INDEX_W'(i),
                      {1'($urandom_range(1)), RATE_W'(rate)});
        end
        cfg_valid <= 1'b0;
    endtask

    // Result checking at every accepted result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            check_selection(out_data);
            results_seen++;
        end
    end

    // Receiver stalls; once it holds off long enough for the block to fill up.
    initial
    begin : receiver
        bit held;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= HOLD_AT)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        foreach (set_rate[i])
            set_rate[i] = '0;

        // After reset: alpha one half, one level at rate zero, average zero.
        add_chunk(24'd0, 32'd1, 1'b1, {24'd0, 32'd0, 16'd0, 3'd0, 1'b0, 1'b0});
        // Zero duration saturates even with zero bytes.
        add_chunk(24'd0, 32'd0, 1'b1,
                  {KBPS_MAX, 32'h7FFF_FF80, 16'd0, 3'd0, 1'b1, 1'b0});
        // With alpha at one the average follows each measurement.
        add_write(CFG_ALPHA, ONE_Q16);
        add_chunk(24'hFF_FFFF, 32'd1, 1'b1,
                  {KBPS_MAX, 32'hFFFF_FF00, 16'd0, 3'd0, 1'b0, 1'b1});
        add_chunk(24'hFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
        add_chunk(24'd1, 32'hFFFF_FFFF, 1'b1, '0);
        add_chunk(24'd2097, 32'd1, 1'b0, '0);
        add_chunk(24'd2098, 32'd1, 1'b1,
                  {KBPS_MAX, 32'hFFFF_FF00, 16'd0, 3'd0, 1'b0, 1'b1});

        // Six ascending levels; alpha above one acts as one.
        add_write(CFG_LEVEL_COUNT, 17'd6);
        add_write(CFG_RATE_0 + 3'd0, 17'd100);
        add_write(CFG_RATE_0 + 3'd1, 17'd200);
        add_write(CFG_RATE_0 + 3'd2, 17'd400);
        add_write(CFG_RATE_0 + 3'd3, 17'd800);
        add_write(CFG_RATE_0 + 3'd4, 17'd1600);
        add_write(CFG_RATE_0 + 3'd5, 17'd3200);
        add_write(CFG_ALPHA, 17'h1_FFFF);
        // Each level's boundary, where the rate equals two thirds of the average.
        add_chunk(24'd150, 32'd8000, 1'b0, '0);
        add_chunk(24'd151, 32'd8000, 1'b0, '0);
        add_chunk(24'd301, 32'd8000, 1'b0, '0);
        add_chunk(24'd601, 32'd8000, 1'b0, '0);
        add_chunk(24'd1201, 32'd8000, 1'b0, '0);
        add_chunk(24'd2401, 32'd8000, 1'b0, '0);
        add_chunk(24'd4800, 32'd8000, 1'b0, '0);
        add_chunk(24'd4801, 32'd8000, 1'b0, '0);
        add_chunk(24'hFF_FFFF, 32'd8000, 1'b0, '0);

        // A level count of zero acts as one, and seven acts as six.
        add_write(CFG_LEVEL_COUNT, 17'd0);
        add_chunk(24'd4801, 32'd8000, 1'b0, '0);
        add_write(CFG_LEVEL_COUNT, 17'd7);
        // Rates out of order: the one below the top wins, then the top wins.
        add_write(CFG_RATE_0 + 3'd4, 17'd50);
        add_write(CFG_RATE_0 + 3'd5, 17'h1_FFFF);
        add_chunk(24'd4801, 32'd8000, 1'b0, '0);
        add_chunk(24'hFF_FFFF, 32'd8000, 1'b0, '0);
        // Alpha zero keeps the average where it is.
        add_write(CFG_ALPHA, 17'd0);
        add_chunk(24'h12_3456, 32'd7, 1'b0, '0);

        send_idle_pct = 12;
        recv_idle_pct = 69;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Scripted part.
        foreach (plan[k])
        begin
            if (plan[k].is_write)
            begin
                wait_quiet();
                write_reg(plan[k].reg_index, plan[k].reg_value);
                cfg_valid <= 1'b0;
            end
            else
            begin
                send_chunk(plan[k].chunk, plan[k].typed, plan[k].known);
            end
        end

        // Random part: three idle patterns, each under three register settings.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / 3)
                0:
                begin
                    send_idle_pct = 12;
                    recv_idle_pct = 69;
                end
                1:
                begin
                    send_idle_pct = 69;
                    recv_idle_pct = 12;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            wait_quiet();
            load_random_settings();
            repeat (RANDOM_ITEMS / SEGMENTS)
                send_chunk(random_chunk(), 1'b0, '0);
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
